FILE: rtl/core/emm_pkg.sv
`default_nettype none
package emm_pkg;

   // input item kinds
   typedef enum logic [1:0] {
      ACT_SAMPLE = 2'd0,
      ACT_TICK   = 2'd1,
      ACT_START  = 2'd2,
      ACT_STOP   = 2'd3
   } action_type;

   // register indexes on the csr port
   localparam logic [1:0] CSR_SCALE     = 2'd0;
   localparam logic [1:0] CSR_STEP      = 2'd1;
   localparam logic [1:0] CSR_THRESHOLD = 2'd2;

   localparam logic [31:0] SCALE_RESET     = 32'd18013952;
   localparam logic [39:0] STEP_RESET      = 40'd65536;
   localparam logic [39:0] THRESHOLD_RESET = 40'd655;

   localparam logic signed [47:0] D48_MAX = 48'sh7FFF_FFFF_FFFF;
   localparam logic signed [47:0] D48_MIN = 48'sh8000_0000_0000;

   typedef struct packed {
      logic [39:0] step;
      logic [39:0] threshold;
   } track_cfg_type;

   // count difference as sign and magnitude
   typedef struct packed {
      action_type  action;
      logic        cap;
      logic        neg;
      logic [31:0] mag;
      logic [31:0] tag;
   } diff_word_type;

   // scaled magnitude in 1/65536 inch
   typedef struct packed {
      action_type  action;
      logic        cap;
      logic        neg;
      logic [47:0] mag;
      logic [31:0] tag;
   } prod_word_type;

   typedef struct packed {
      logic signed [47:0] distance;
      logic [31:0]        tag_out;
      logic               recorded;
      logic               trigger;
      logic               moving;
      logic signed [47:0] run_min;
      logic signed [47:0] run_max;
   } rsp_word_type;

endpackage
`default_nettype wire

FILE: rtl/core/emm_diff.sv
`default_nettype none
module emm_diff (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           in_valid,
   output logic                in_ready,
   input  wire emm_pkg::action_type in_action,
   input  wire logic [31:0]    in_count,
   input  wire logic [31:0]    in_tag,
   output logic                out_valid,
   input  wire logic           out_ready,
   output emm_pkg::diff_word_type out_word
);
   import emm_pkg::*;

   logic [31:0]   base_count_ff, base_count_in;
   logic          base_valid_ff, base_valid_in;
   logic          capturing_ff, capturing_in;
   logic          valid_ff, valid_in;
   diff_word_type word_ff, word_in;
   logic          take;
   logic [31:0]   base_eff;
   logic [32:0]   diff;
   logic [31:0]   diff_abs;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_comb begin
      // a sample that latches the base sees a zero difference
      base_eff = base_valid_ff ? base_count_ff : in_count;
      diff     = {base_eff[31], base_eff} - {in_count[31], in_count};
      // difference never reaches -2^32, so the magnitude fits 32 bits
      diff_abs = diff[32] ? 32'(33'd0 - diff) : diff[31:0];

      word_in.action = in_action;
      word_in.cap    = capturing_ff;
      word_in.neg    = diff[32];
      word_in.mag    = diff_abs;
      word_in.tag    = in_tag;

      base_count_in = base_count_ff;
      base_valid_in = base_valid_ff;
      capturing_in  = capturing_ff;
      if (take) begin
         unique case (in_action)
            ACT_SAMPLE: begin
               if (!base_valid_ff) begin
                  base_count_in = in_count;
                  base_valid_in = 1'b1;
               end
            end
            ACT_TICK: begin
            end
            ACT_START: begin
               base_valid_in = 1'b0;
               capturing_in  = 1'b1;
            end
            ACT_STOP: begin
               capturing_in = 1'b0;
            end
         endcase
      end

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_count_ff <= '0;
         base_valid_ff <= 1'b0;
         capturing_ff  <= 1'b0;
         valid_ff      <= 1'b0;
      end else begin
         base_count_ff <= base_count_in;
         base_valid_ff <= base_valid_in;
         capturing_ff  <= capturing_in;
         valid_ff      <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/emm_scale.sv
`default_nettype none
module emm_scale (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic [31:0]       scale,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire emm_pkg::diff_word_type in_word,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output emm_pkg::prod_word_type out_word
);
   import emm_pkg::*;

   logic          valid_ff, valid_in;
   prod_word_type word_ff, word_in;
   logic          take;
   logic [63:0]   prod;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_comb begin
      // q0.32 scale, keep 16 fraction bits
      prod = 64'(in_word.mag) * 64'(scale);

      word_in.action = in_word.action;
      word_in.cap    = in_word.cap;
      word_in.neg    = in_word.neg;
      word_in.mag    = prod[63:16];
      word_in.tag    = in_word.tag;

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/emm_track.sv
`default_nettype none
module emm_track (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire emm_pkg::track_cfg_type cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire emm_pkg::prod_word_type in_word,
   output logic                   out_valid,
   input  wire logic              out_ready,
   output emm_pkg::rsp_word_type  out_word
);
   import emm_pkg::*;

   logic signed [47:0] next_mark_ff, next_mark_in;
   logic signed [47:0] window_min_ff, window_min_in;
   logic signed [47:0] window_max_ff, window_max_in;
   logic signed [47:0] span_min_ff, span_min_in;
   logic signed [47:0] span_max_ff, span_max_in;
   logic               motion_flag_ff, motion_flag_in;
   logic               valid_ff, valid_in;
   rsp_word_type       word_ff, word_in;
   logic               take;
   logic               sample_hit;
   logic               trig;
   logic signed [47:0] dist_sat;
   logic [47:0]        mark_sum;
   logic signed [49:0] spread;

   assign in_ready  = !valid_ff || out_ready;
   assign take      = in_valid && in_ready;
   assign out_valid = valid_ff;
   assign out_word  = word_ff;

   always_comb begin
      // saturate signed magnitude into 48 bits
      if (in_word.neg) begin
         dist_sat = in_word.mag[47] ? D48_MIN : $signed(48'd0 - in_word.mag);
      end else begin
         dist_sat = in_word.mag[47] ? D48_MAX : $signed(in_word.mag);
      end

      // mark stays non-negative, so bit 47 of the sum means overflow
      mark_sum = $unsigned(next_mark_ff) + {8'd0, cfg.step};
      spread   = {{2{window_max_ff[47]}}, window_max_ff}
               - {{2{window_min_ff[47]}}, window_min_ff};

      sample_hit = (in_word.action == ACT_SAMPLE) && in_word.cap;
      trig       = sample_hit && (dist_sat > next_mark_ff);

      next_mark_in   = next_mark_ff;
      window_min_in  = window_min_ff;
      window_max_in  = window_max_ff;
      span_min_in    = span_min_ff;
      span_max_in    = span_max_ff;
      motion_flag_in = motion_flag_ff;
      if (take) begin
         unique case (in_word.action)
            ACT_SAMPLE: begin
               if (in_word.cap) begin
                  if (trig) begin
                     next_mark_in = mark_sum[47] ? D48_MAX : $signed(mark_sum);
                  end
                  if (dist_sat < window_min_ff) window_min_in = dist_sat;
                  if (dist_sat > window_max_ff) window_max_in = dist_sat;
                  if (dist_sat < span_min_ff)   span_min_in   = dist_sat;
                  if (dist_sat > span_max_ff)   span_max_in   = dist_sat;
               end
            end
            ACT_TICK: begin
               if (in_word.cap) begin
                  motion_flag_in = spread > $signed({10'd0, cfg.threshold});
                  window_min_in  = D48_MAX;
                  window_max_in  = D48_MIN;
               end
            end
            ACT_START: begin
               next_mark_in   = '0;
               window_min_in  = D48_MAX;
               window_max_in  = D48_MIN;
               span_min_in    = D48_MAX;
               span_max_in    = D48_MIN;
               motion_flag_in = 1'b1;
            end
            ACT_STOP: begin
            end
         endcase
      end

      word_in.distance = sample_hit ? dist_sat : '0;
      word_in.tag_out  = sample_hit ? in_word.tag : '0;
      word_in.recorded = sample_hit;
      word_in.trigger  = trig;
      word_in.moving   = motion_flag_in;
      word_in.run_min  = span_min_in;
      word_in.run_max  = span_max_in;

      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_mark_ff   <= '0;
         window_min_ff  <= D48_MAX;
         window_max_ff  <= D48_MIN;
         span_min_ff    <= D48_MAX;
         span_max_ff    <= D48_MIN;
         motion_flag_ff <= 1'b1;
         valid_ff       <= 1'b0;
      end else begin
         next_mark_ff   <= next_mark_in;
         window_min_ff  <= window_min_in;
         window_max_ff  <= window_max_in;
         span_min_ff    <= span_min_in;
         span_max_ff    <= span_max_in;
         motion_flag_ff <= motion_flag_in;
         valid_ff       <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         word_ff <= word_in;
      end
   end

endmodule
`default_nettype wire

FILE: rtl/core/encoder_odometer_motion_monitor.sv
// pipeline: count difference, then scale multiply, then mark and min/max
// tracking, each registered before the result shows on rsp
// throughput: one word per cycle while the result side is not stalled
// ready runs back combinationally, so a stall at rsp can reach req_tready
// reset: synchronous, clears all stage valids, base and capture state, mark,
// windows and run span to their idle values and loads the register defaults
`default_nettype none
module encoder_odometer_motion_monitor (
   input  wire logic         clock,
   input  wire logic         reset,
   // request stream
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [63:0]  req_tdata,   // count[31:0], sample_tag[63:32]
   input  wire logic [1:0]   req_tuser,   // action[1:0]
   // result stream
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [183:0]      rsp_tdata,   // distance[47:0], tag_out[79:48],
                                          // trigger[80], moving[81],
                                          // run_min[129:82], run_max[177:130], zero pad
   output logic [0:0]        rsp_tuser,   // recorded[0]
   // register writes
   input  wire logic         csr_we,
   input  wire logic [1:0]   csr_index,
   input  wire logic [39:0]  csr_wdata
);
   import emm_pkg::*;

   // configuration registers; write only while idle, the block does not enforce it
   logic [31:0]   scale_ff, scale_in;
   logic [39:0]   step_ff, step_in;
   logic [39:0]   threshold_ff, threshold_in;
   track_cfg_type track_cfg;

   // stage handshakes
   logic          diff_valid, diff_ready;
   diff_word_type diff_word;
   logic          prod_valid, prod_ready;
   prod_word_type prod_word;
   rsp_word_type  rsp_word;

   always_comb begin
      scale_in     = scale_ff;
      step_in      = step_ff;
      threshold_in = threshold_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_SCALE:     scale_in     = csr_wdata[31:0];
            CSR_STEP:      step_in      = csr_wdata;
            CSR_THRESHOLD: threshold_in = csr_wdata;
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff     <= SCALE_RESET;
         step_ff      <= STEP_RESET;
         threshold_ff <= THRESHOLD_RESET;
      end else begin
         scale_ff     <= scale_in;
         step_ff      <= step_in;
         threshold_ff <= threshold_in;
      end
   end

   assign track_cfg.step      = step_ff;
   assign track_cfg.threshold = threshold_ff;

   // stage 1: base latch, capture flag, count difference
   emm_diff u_diff (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_action (action_type'(req_tuser)),
      .in_count  (req_tdata[31:0]),
      .in_tag    (req_tdata[63:32]),
      .out_valid (diff_valid),
      .out_ready (diff_ready),
      .out_word  (diff_word)
   );

   // stage 2: magnitude times scale
   emm_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .scale     (scale_ff),
      .in_valid  (diff_valid),
      .in_ready  (diff_ready),
      .in_word   (diff_word),
      .out_valid (prod_valid),
      .out_ready (prod_ready),
      .out_word  (prod_word)
   );

   // stage 3: saturation, trigger mark, window and run span, result register
   emm_track u_track (
      .clock     (clock),
      .reset     (reset),
      .cfg       (track_cfg),
      .in_valid  (prod_valid),
      .in_ready  (prod_ready),
      .in_word   (prod_word),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_word  (rsp_word)
   );

   // pack the result word
   assign rsp_tdata = {6'd0, rsp_word.run_max, rsp_word.run_min, rsp_word.moving,
                       rsp_word.trigger, rsp_word.tag_out, rsp_word.distance};
   assign rsp_tuser = rsp_word.recorded;

   // no result left over from before reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // an accepted word always lands in the first stage
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> diff_valid)
      else $error("accepted word lost at first stage");

   // a trigger only comes with a recorded sample
   a_trigger_recorded: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[80] |-> rsp_tuser[0])
      else $error("trigger without recorded sample");

   // a recorded distance lies inside the run span
   a_span_bounds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         ($signed(rsp_tdata[129:82]) <= $signed(rsp_tdata[47:0])) &&
         ($signed(rsp_tdata[47:0]) <= $signed(rsp_tdata[177:130])))
      else $error("recorded distance outside run span");

endmodule
`default_nettype wire

FILE: sim/testbench.sv
`timescale 1ns / 100ps
module testbench;
   import emm_pkg::*;

   // 48-bit distance limits held in 64-bit arithmetic
   localparam longint DIST_MAX = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint DIST_MIN = -64'sh0000_8000_0000_0000;
   localparam logic [39:0] REG40_MAX = 40'hFF_FFFF_FFFF;
   // cycles without any handshake before the run is called hung
   localparam int QUIET_LIMIT = 2000;

   // predictor of the odometer plus the store of words it still expects
   class odometer_scoreboard;
      bit [31:0]    scale;
      bit [39:0]    step;
      bit [39:0]    threshold;
      bit [31:0]    base;
      bit           base_ok;
      bit           capturing;
      bit           motion;
      longint       mark;
      longint       win_lo;
      longint       win_hi;
      longint       run_lo;
      longint       run_hi;
      rsp_word_type predicted_words[$];
      int           errors;

      function new();
         scale     = SCALE_RESET;
         step      = STEP_RESET;
         threshold = THRESHOLD_RESET;
         base      = '0;
         base_ok   = 1'b0;
         capturing = 1'b0;
         motion    = 1'b1;
         mark      = 0;
         win_lo    = DIST_MAX;
         win_hi    = DIST_MIN;
         run_lo    = DIST_MAX;
         run_hi    = DIST_MIN;
         errors    = 0;
      endfunction

      function void write_reg(logic [1:0] index, logic [39:0] value);
         case (index)
            CSR_SCALE:     scale = value[31:0];
            CSR_STEP:      step = value;
            CSR_THRESHOLD: threshold = value;
            default: ;
         endcase
      endfunction

      // sign * floor(|diff| * scale / 2^16), clipped to 48 bits
      function longint counts_to_distance(longint diff);
         bit [63:0] mag;
         bit [63:0] prod;
         mag  = (diff < 0) ? -diff : diff;
         prod = (mag * {32'b0, scale}) >> 16;
         if (diff >= 0)
            return (prod > 64'h0000_7FFF_FFFF_FFFF) ? DIST_MAX : longint'(prod);
         if (prod > 64'h0000_8000_0000_0000)
            return DIST_MIN;
         return -longint'(prod);
      endfunction

      function void note_word(action_type act, logic [31:0] count, logic [31:0] tag);
         rsp_word_type w;
         longint       dist_now;
         longint       base_s;
         longint       count_s;
         longint       next;
         bit           rec;
         bit           trig;
         dist_now = 0;
         rec  = 1'b0;
         trig = 1'b0;
         case (act)
            ACT_SAMPLE: begin
               if (!base_ok) begin
                  base    = count;
                  base_ok = 1'b1;
               end
               if (capturing) begin
                  base_s   = $signed(base);
                  count_s  = $signed(count);
                  dist_now = counts_to_distance(base_s - count_s);
                  rec      = 1'b1;
                  if (dist_now > mark) begin
                     next = mark + longint'(step);
                     mark = (next > DIST_MAX) ? DIST_MAX : next;
                     trig = 1'b1;
                  end
                  if (dist_now < win_lo) win_lo = dist_now;
                  if (dist_now > win_hi) win_hi = dist_now;
                  if (dist_now < run_lo) run_lo = dist_now;
                  if (dist_now > run_hi) run_hi = dist_now;
               end
            end
            ACT_TICK: begin
               if (capturing) begin
                  motion = (win_hi - win_lo) > longint'(threshold);
                  win_lo = DIST_MAX;
                  win_hi = DIST_MIN;
               end
            end
            ACT_START: begin
               base_ok   = 1'b0;
               mark      = 0;
               capturing = 1'b1;
               win_lo    = DIST_MAX;
               win_hi    = DIST_MIN;
               run_lo    = DIST_MAX;
               run_hi    = DIST_MIN;
               motion    = 1'b1;
            end
            default: capturing = 1'b0;
         endcase
         w.distance = dist_now[47:0];
         w.tag_out  = rec ? tag : 32'd0;
         w.recorded = rec;
         w.trigger  = trig;
         w.moving   = motion;
         w.run_min  = run_lo[47:0];
         w.run_max  = run_hi[47:0];
         predicted_words.insert(predicted_words.size(), w);
      endfunction

      function void compare_field(string field, logic [63:0] want, logic [63:0] seen);
         if (want !== seen) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, field, want, seen);
            errors++;
         end
      endfunction

      function void check_word(rsp_word_type seen);
         rsp_word_type want;
         if (predicted_words.size() == 0) begin
            $display("%0t: unexpected result word, expected none actual %h", $time, seen);
            errors++;
            return;
         end
         want = predicted_words.pop_front();
         compare_field("distance", 64'(want.distance), 64'(seen.distance));
         compare_field("tag_out", 64'(want.tag_out), 64'(seen.tag_out));
         compare_field("recorded", 64'(want.recorded), 64'(seen.recorded));
         compare_field("trigger", 64'(want.trigger), 64'(seen.trigger));
         compare_field("moving", 64'(want.moving), 64'(seen.moving));
         compare_field("run_min", 64'(want.run_min), 64'(seen.run_min));
         compare_field("run_max", 64'(want.run_max), 64'(seen.run_max));
      endfunction
   endclass

   // every input of the block starts at a known value
   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [63:0]  req_tdata = '0;   // count[31:0], sample_tag[63:32]
   logic [1:0]   req_tuser = '0;   // action[1:0]
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [183:0] rsp_tdata;        // distance[47:0], tag_out[79:48], trigger[80],
                                   // moving[81], run_min[129:82], run_max[177:130]
   logic [0:0]   rsp_tuser;        // recorded[0]
   logic         csr_we = 1'b0;
   logic [1:0]   csr_index = '0;
   logic [39:0]  csr_wdata = '0;

   odometer_scoreboard sb;

   // sender burst state
   int burst_left = 0;
   bit gaps_on = 1'b1;
   int words_sent = 0;

   // receiver stall pattern state
   int       stall_cycle = 0;
   int       stall_mode = 0;
   bit [7:0] stall_mask = 8'hFF;

   int quiet_cycles = 0;

   encoder_odometer_motion_monitor u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // note accepted words and check results, both sampled at the edge itself
   always @(posedge clock) begin : word_monitor
      rsp_word_type seen;
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_word(action_type'(req_tuser), req_tdata[31:0], req_tdata[63:32]);
         if (rsp_tvalid && rsp_tready) begin
            seen.distance = rsp_tdata[47:0];
            seen.tag_out  = rsp_tdata[79:48];
            seen.trigger  = rsp_tdata[80];
            seen.moving   = rsp_tdata[81];
            seen.run_min  = rsp_tdata[129:82];
            seen.run_max  = rsp_tdata[177:130];
            seen.recorded = rsp_tuser[0];
            sb.check_word(seen);
         end
      end
   end

   // receiver back-pressure, a new pattern whenever stall_cycle[6:0] wraps to zero
   always @(posedge clock) begin
      stall_cycle <= stall_cycle + 1;
      if (stall_cycle[6:0] == 7'd0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_mask <= 8'($urandom) | 8'd1;
      end
      case (stall_mode)
         0: rsp_tready <= 1'b1;                              // no stalls at all
         1: rsp_tready <= ($urandom_range(0, 2) != 0);       // scattered stalls
         2: rsp_tready <= stall_mask[stall_cycle[2:0]];      // repeating mask
         default: rsp_tready <= (stall_cycle[4:0] >= 5'd12); // long stall at the start of each stall_cycle[4:0] wrap
      endcase
   end

   // hang detector: nothing moved on either side for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[encoder_odometer_motion_monitor] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // one word on the request side, with a random gap before each burst if gaps_on
   task automatic send_word(action_type act, logic [31:0] count, logic [31:0] tag);
      int gap;
      if (burst_left == 0) begin
         gap = gaps_on ? $urandom_range(1, 9) : 0;
         burst_left = $urandom_range(1, 24);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= act;
      req_tdata  <= {tag, count};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      burst_left--;
      words_sent++;
   endtask

   // registers change only with the pipeline empty
   task automatic write_reg(logic [1:0] index, logic [39:0] value);
      csr_we    <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      sb.write_reg(index, value);
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // stop sending and let every predicted word come back
   task automatic drain();
      req_tvalid <= 1'b0;
      // let the monitor note the last accepted word before polling the store
      @(posedge clock);
      while (sb.predicted_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   initial begin
      logic [31:0] c0;
      logic [31:0] count_now;
      logic [31:0] tag_now;
      int          phase;
      int          n_samples;
      int          span;
      int          roll;
      bit          backward_mix;
      bit          noise_on;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: idle handling, first-sample base, both directions, restart
      c0 = $urandom;
      send_word(ACT_SAMPLE, 32'd1234, 32'h0000_0001);     // latches base while stopped
      send_word(ACT_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);  // tick while stopped is ignored
      send_word(ACT_STOP, 32'd0, 32'd0);                  // stop while stopped
      send_word(ACT_START, 32'd0, 32'd0);
      send_word(ACT_TICK, 32'd0, 32'd0);                  // empty window clears moving
      send_word(ACT_SAMPLE, c0, 32'hFFFF_FFFF);           // new base, zero distance
      send_word(ACT_SAMPLE, c0 - 32'd300, 32'h8000_0000); // forward, passes first mark
      send_word(ACT_SAMPLE, c0 + 32'd300, 32'h7FFF_FFFF); // backward, negative distance
      send_word(ACT_TICK, 32'd0, 32'd0);                  // wide spread, moving
      send_word(ACT_SAMPLE, c0, 32'h0000_00AA);
      send_word(ACT_TICK, 32'd0, 32'd0);                  // zero spread, not moving
      send_word(ACT_START, 32'd0, 32'd0);                 // restart while capturing
      send_word(ACT_SAMPLE, 32'h7FFF_FFFF, 32'd0);
      send_word(ACT_SAMPLE, 32'h8000_0000, 32'h5555_5555); // widest count difference
      send_word(ACT_STOP, 32'd0, 32'd0);
      send_word(ACT_SAMPLE, 32'h1111_1111, 32'd7);        // stopped, base already held
      drain();

      // full scale: the negative end clips
      write_reg(CSR_SCALE, 40'h00_FFFF_FFFF);
      send_word(ACT_START, 32'd0, 32'd0);
      send_word(ACT_SAMPLE, 32'h8000_0000, 32'h0000_0010);
      send_word(ACT_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0011); // clips to most negative
      send_word(ACT_SAMPLE, 32'h8000_0000, 32'h0000_0012);
      send_word(ACT_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0013);
      send_word(ACT_TICK, 32'd0, 32'd0);
      send_word(ACT_STOP, 32'd0, 32'd0);

      // random phases: new settings, idling styles, then one capture run each
      phase = 0;
      while (words_sent < 1225) begin
         drain();
         if (phase == 0 || $urandom_range(0, 4) < 3) begin
            case ($urandom_range(0, 4))
               0: write_reg(CSR_SCALE, 40'd0);
               1: write_reg(CSR_SCALE, 40'd1);
               2: write_reg(CSR_SCALE, 40'h00_FFFF_FFFF);
               3: write_reg(CSR_SCALE, 40'(SCALE_RESET));
               default: write_reg(CSR_SCALE, {8'($urandom), 32'($urandom)});
            endcase
         end
         if (phase == 0 || $urandom_range(0, 4) < 3) begin
            case ($urandom_range(0, 4))
               0: write_reg(CSR_STEP, 40'd0);
               1: write_reg(CSR_STEP, 40'd1);
               2: write_reg(CSR_STEP, REG40_MAX);
               3: write_reg(CSR_STEP, STEP_RESET);
               default: write_reg(CSR_STEP, 40'($urandom_range(1, 1 << 20)));
            endcase
         end
         if (phase == 0 || $urandom_range(0, 4) < 3) begin
            case ($urandom_range(0, 4))
               0: write_reg(CSR_THRESHOLD, 40'd0);
               1: write_reg(CSR_THRESHOLD, REG40_MAX);
               2: write_reg(CSR_THRESHOLD, THRESHOLD_RESET);
               3: write_reg(CSR_THRESHOLD, 40'($urandom_range(0, 100000)));
               default: write_reg(CSR_THRESHOLD, {8'($urandom), 32'($urandom)});
            endcase
         end
         gaps_on = ($urandom_range(0, 3) != 0);

         if (phase == 3) begin
            // far run: distance pinned at the top, marks climb until they clip
            write_reg(CSR_SCALE, 40'h00_FFFF_FFFF);
            write_reg(CSR_STEP, REG40_MAX);
            send_word(ACT_START, 32'd0, 32'd0);
            send_word(ACT_SAMPLE, 32'h7FFF_FFFF, 32'd0);
            for (int i = 0; i < 140; i++)
               send_word(ACT_SAMPLE, 32'h8000_0000 + 32'($urandom_range(0, 15)), 32'(i));
            send_word(ACT_TICK, 32'd0, 32'd0);
            send_word(ACT_STOP, 32'd0, 32'd0);
         end else begin
            n_samples    = $urandom_range(10, 80);
            backward_mix = $urandom_range(0, 1);
            noise_on     = ($urandom_range(0, 2) == 0);
            case ($urandom_range(0, 3))
               0: span = 3;
               1: span = 300;
               2: span = 5000;
               default: span = 200000;
            endcase
            count_now = $urandom;
            tag_now   = $urandom;
            send_word(ACT_START, $urandom, $urandom);
            for (int i = 0; i < n_samples; i++) begin
               roll = $urandom_range(0, 99);
               if (noise_on && roll < 6) begin
                  // stray word of any kind, may restart or stop the run
                  send_word(action_type'($urandom_range(0, 3)), $urandom, $urandom);
               end else if (roll < 20) begin
                  send_word(ACT_TICK, $urandom, $urandom);
               end else begin
                  if (backward_mix && $urandom_range(0, 3) == 0)
                     count_now = count_now + 32'($urandom_range(0, span));
                  else
                     count_now = count_now - 32'($urandom_range(0, span));
                  if ($urandom_range(0, 49) == 0)
                     count_now = $urandom;   // encoder jump anywhere
                  tag_now = tag_now + 32'd1;
                  send_word(ACT_SAMPLE, count_now, tag_now);
               end
            end
            if ($urandom_range(0, 1) == 1) begin
               send_word(ACT_STOP, $urandom, $urandom);
               send_word(ACT_SAMPLE, $urandom, $urandom);
               send_word(ACT_TICK, $urandom, $urandom);
            end
         end
         phase++;
      end

      // wind down: everything predicted must arrive, then nothing more
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.predicted_words.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.predicted_words.size() == 0)
         $display("[encoder_odometer_motion_monitor] OK");
      else
         $display("[encoder_odometer_motion_monitor] ERROR");
      $finish;
   end

endmodule
